// ===== hw/rtl/etmc_pkg.sv =====
// Package: shared constants, arctangent table and word type for the TRS compose core.
`default_nettype none
package etmc_pkg;

  localparam int TrigBitsDef = 16;
  localparam int CordicLen   = 24;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

  typedef logic signed [CordicW-1:0] cw_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] t;
    begin
      unique case (i)
        0:  t = 34'sd536870912;
        1:  t = 34'sd316933406;
        2:  t = 34'sd167458907;
        3:  t = 34'sd85004756;
        4:  t = 34'sd42667331;
        5:  t = 34'sd21354465;
        6:  t = 34'sd10679838;
        7:  t = 34'sd5340245;
        8:  t = 34'sd2670163;
        9:  t = 34'sd1335087;
        10: t = 34'sd667544;
        11: t = 34'sd333772;
        12: t = 34'sd166886;
        13: t = 34'sd83443;
        14: t = 34'sd41722;
        15: t = 34'sd20861;
        16: t = 34'sd10430;
        17: t = 34'sd5215;
        18: t = 34'sd2608;
        19: t = 34'sd1304;
        20: t = 34'sd652;
        21: t = 34'sd326;
        22: t = 34'sd163;
        23: t = 34'sd81;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/etmc_cordic.sv =====
// Pipelined rotation-mode CORDIC: one iteration per register stage, sine and cosine out.
`default_nettype none
module etmc_cordic #(
  parameter int TRIG_BITS = etmc_pkg::TrigBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic [15:0]            angle,
  output logic signed [TRIG_BITS+1:0] sin_q,
  output logic signed [TRIG_BITS+1:0] cos_q
);
  localparam int N  = (TRIG_BITS < etmc_pkg::CordicLen) ? TRIG_BITS : etmc_pkg::CordicLen;
  localparam int SH = 30 - TRIG_BITS;
  localparam int OW = TRIG_BITS + 2;

  etmc_pkg::cw_t x_r [N+1];
  etmc_pkg::cw_t y_r [N+1];
  etmc_pkg::cw_t z_r [N+1];
  logic          f_r [N+1];

  etmc_pkg::cw_t z0;
  logic          f0;
  logic [1:0]    quad;

  assign quad = angle[15:14];

  always_comb begin
    z0 = {2'b00, angle, 16'h0000};
    f0 = 1'b0;
    // reduce the two middle quadrants by a half turn and flip the result
    if (quad == 2'b01 || quad == 2'b10) begin
      z0 = z0 - (etmc_pkg::cw_t'(1) <<< 31);
      f0 = 1'b1;
    end else if (quad == 2'b11) begin
      z0 = z0 - (etmc_pkg::cw_t'(1) <<< 32);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= etmc_pkg::CordicX0;
      y_r[0] <= '0;
      z_r[0] <= z0;
      f_r[0] <= f0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (adv) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][etmc_pkg::CordicW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - etmc_pkg::atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + etmc_pkg::atan_turn(i);
        end
      end
    end
  end

  function automatic logic signed [OW-1:0] rnd_clamp(input etmc_pkg::cw_t v, input logic f);
    etmc_pkg::cw_t a;
    etmc_pkg::cw_t r;
    begin
      a = f ? -v : v;
      if (SH > 0) r = (a + (etmc_pkg::cw_t'(1) <<< (SH - 1))) >>> SH;
      else        r = a <<< (-SH);
      if (r > (etmc_pkg::cw_t'(1) <<< TRIG_BITS))       r = etmc_pkg::cw_t'(1) <<< TRIG_BITS;
      else if (r < -(etmc_pkg::cw_t'(1) <<< TRIG_BITS)) r = -(etmc_pkg::cw_t'(1) <<< TRIG_BITS);
      return r[OW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_q <= rnd_clamp(x_r[N], f_r[N]);
      sin_q <= rnd_clamp(y_r[N], f_r[N]);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/etmc_compose.sv =====
// Rotation entries and scaling: products, rounding and saturation over four register stages.
`default_nettype none
module etmc_compose #(
  parameter int TRIG_BITS = etmc_pkg::TrigBitsDef
) (
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic signed [TRIG_BITS+1:0] sx,
  input  wire logic signed [TRIG_BITS+1:0] cx,
  input  wire logic signed [TRIG_BITS+1:0] sy,
  input  wire logic signed [TRIG_BITS+1:0] cy,
  input  wire logic signed [TRIG_BITS+1:0] sz,
  input  wire logic signed [TRIG_BITS+1:0] cz,
  input  wire logic signed [23:0]     scx,
  input  wire logic signed [23:0]     scy,
  input  wire logic signed [23:0]     scz,
  output logic signed [31:0]          m [9]
);
  localparam int TW = TRIG_BITS + 2;
  localparam int PW = 2 * TW;
  localparam int RW = PW + 2;
  localparam int EW = RW - TRIG_BITS + 1;
  localparam int SW = EW + 24;

  typedef logic signed [PW-1:0] p_t;
  typedef logic signed [RW-1:0] r_t;
  typedef logic signed [EW-1:0] e_t;
  typedef logic signed [SW-1:0] s_t;

  // stage A: pair products, delay singles
  p_t szsx_a, czsx_a, czcy_a, szcy_a, cxsy_a, szcx_a, czcx_a, czsy_a, szsy_a, cxcy_a;
  logic signed [TW-1:0] sx_a, sy_a, cy_a;
  logic signed [23:0] sc_a [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      szsx_a <= sz * sx;  czsx_a <= cz * sx;
      czcy_a <= cz * cy;  szcy_a <= sz * cy;
      cxsy_a <= cx * sy;  szcx_a <= sz * cx;
      czcx_a <= cz * cx;  czsy_a <= cz * sy;
      szsy_a <= sz * sy;  cxcy_a <= cx * cy;
      sx_a <= sx; sy_a <= sy; cy_a <= cy;
      sc_a[0] <= scx; sc_a[1] <= scy; sc_a[2] <= scz;
    end
  end

  function automatic p_t rnd_p(input p_t v);
    return (v + (p_t'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
  endfunction

  // stage B: triple products and rotation entries at double precision
  p_t q0, q1;
  r_t r_b [9];
  logic signed [23:0] sc_b [3];
  assign q0 = rnd_p(szsx_a);
  assign q1 = rnd_p(czsx_a);

  always_ff @(posedge clk) begin
    if (adv) begin
      r_b[0] <= r_t'(czcy_a) - r_t'($signed(q0[TW-1:0]) * sy_a);
      r_b[1] <= r_t'(szcy_a) + r_t'($signed(q1[TW-1:0]) * sy_a);
      r_b[2] <= -r_t'(cxsy_a);
      r_b[3] <= -r_t'(szcx_a);
      r_b[4] <= r_t'(czcx_a);
      r_b[5] <= r_t'(sx_a) <<< TRIG_BITS;
      r_b[6] <= r_t'(czsy_a) + r_t'($signed(q0[TW-1:0]) * cy_a);
      r_b[7] <= r_t'(szsy_a) - r_t'($signed(q1[TW-1:0]) * cy_a);
      r_b[8] <= r_t'(cxcy_a);
      sc_b <= sc_a;
    end
  end

  // stage C: round entries and scale
  s_t p_c [9];
  for (genvar k = 0; k < 9; k++) begin : g_sc
    r_t rr;
    assign rr = (r_b[k] + (r_t'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
    always_ff @(posedge clk) begin
      if (adv) p_c[k] <= $signed(rr[EW-1:0]) * sc_b[k/3];
    end

    // stage D: round to Q16.16 and saturate
    s_t v;
    assign v = (p_c[k] + (s_t'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v > s_t'(32'sh7fffffff))       m[k] <= 32'sh7fffffff;
        else if (v < -s_t'(33'sh80000000)) m[k] <= 32'sh80000000;
        else                               m[k] <= v[31:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/euler_trs_matrix_compose_core.sv =====
// Top level: pose in, TRS model matrix out, fully pipelined.
// Channel | Ports                     | Handshake
// in      | in_pos_*, in_angle_*, ... | start (busy is always low)
// out     | out_col*_row*, out_trans_*| done strobe, one cycle
// One item per cycle; an item passes the CORDIC input
// register, one register per iteration, the sine/cosine rounding register
// and the four product/round stages.
// busy is held low; the pipeline never stalls as results cannot be held off.
// Synchronous active-low reset clears only the valid bits.
`default_nettype none
module euler_trs_matrix_compose_core #(
  parameter int TRIG_BITS = etmc_pkg::TrigBitsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic [15:0]        in_angle_x,
  input  wire logic [15:0]        in_angle_y,
  input  wire logic [15:0]        in_angle_z,
  input  wire logic signed [23:0] in_scale_x,
  input  wire logic signed [23:0] in_scale_y,
  input  wire logic signed [23:0] in_scale_z,
  output logic      done,
  output logic signed [31:0] out_col0_row0,
  output logic signed [31:0] out_col0_row1,
  output logic signed [31:0] out_col0_row2,
  output logic signed [31:0] out_col1_row0,
  output logic signed [31:0] out_col1_row1,
  output logic signed [31:0] out_col1_row2,
  output logic signed [31:0] out_col2_row0,
  output logic signed [31:0] out_col2_row1,
  output logic signed [31:0] out_col2_row2,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);
  localparam int N   = (TRIG_BITS < etmc_pkg::CordicLen) ? TRIG_BITS : etmc_pkg::CordicLen;
  localparam int CL  = N + 2;
  localparam int LAT = CL + 4;
  localparam int TW  = TRIG_BITS + 2;

  logic adv;
  assign adv  = 1'b1;
  assign busy = 1'b0;

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], start};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end
  assign done = vld_r[LAT-1];

  // hold scale alongside the CORDIC and position alongside the whole pipeline
  logic signed [23:0] scx_r [CL], scy_r [CL], scz_r [CL];
  logic signed [31:0] px_r [LAT], py_r [LAT], pz_r [LAT];
  always_ff @(posedge clk) begin
    scx_r[0] <= in_scale_x; scy_r[0] <= in_scale_y; scz_r[0] <= in_scale_z;
    px_r[0] <= in_pos_x; py_r[0] <= in_pos_y; pz_r[0] <= in_pos_z;
    for (int i = 1; i < CL; i++) begin
      scx_r[i] <= scx_r[i-1]; scy_r[i] <= scy_r[i-1]; scz_r[i] <= scz_r[i-1];
    end
    for (int i = 1; i < LAT; i++) begin
      px_r[i] <= px_r[i-1]; py_r[i] <= py_r[i-1]; pz_r[i] <= pz_r[i-1];
    end
  end

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  etmc_cordic #(.TRIG_BITS(TRIG_BITS)) u_cx (
    .clk, .adv, .angle(in_angle_x), .sin_q(sx), .cos_q(cx)
  );
  etmc_cordic #(.TRIG_BITS(TRIG_BITS)) u_cy (
    .clk, .adv, .angle(in_angle_y), .sin_q(sy), .cos_q(cy)
  );
  etmc_cordic #(.TRIG_BITS(TRIG_BITS)) u_cz (
    .clk, .adv, .angle(in_angle_z), .sin_q(sz), .cos_q(cz)
  );

  logic signed [31:0] m [9];
  etmc_compose #(.TRIG_BITS(TRIG_BITS)) u_comp (
    .clk, .adv, .sx, .cx, .sy, .cy, .sz, .cz,
    .scx(scx_r[CL-1]), .scy(scy_r[CL-1]), .scz(scz_r[CL-1]), .m
  );

  assign out_col0_row0 = m[0];
  assign out_col0_row1 = m[1];
  assign out_col0_row2 = m[2];
  assign out_col1_row0 = m[3];
  assign out_col1_row1 = m[4];
  assign out_col1_row2 = m[5];
  assign out_col2_row0 = m[6];
  assign out_col2_row1 = m[7];
  assign out_col2_row2 = m[8];
  assign out_trans_x = px_r[LAT-1];
  assign out_trans_y = py_r[LAT-1];
  assign out_trans_z = pz_r[LAT-1];
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the TRS model matrix compose core: predicts each matrix and checks every result.
`timescale 1ns / 1ps
module tb;

  localparam int TrigBits = etmc_pkg::TrigBitsDef;
  localparam int Iters    = (TrigBits < etmc_pkg::CordicLen) ? TrigBits : etmc_pkg::CordicLen;
  localparam int Latency  = Iters + 6;
  localparam longint CycleLimit = 400000;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [15:0]        ang_x, ang_y, ang_z;
    logic signed [23:0] scl_x, scl_y, scl_z;
  } pose_t;

  typedef struct {
    logic signed [31:0] m[9];
    logic signed [31:0] t[3];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, done;
  pose_t cur = '{default: '0};
  logic signed [31:0] out_m[9];
  logic signed [31:0] out_t[3];

  matrix_t matrix_q[$];
  int     send_idle_pct = 0;
  bit     failed = 1'b0;
  longint cycles = 0;

  euler_trs_matrix_compose_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(cur.pos_x), .in_pos_y(cur.pos_y), .in_pos_z(cur.pos_z),
    .in_angle_x(cur.ang_x), .in_angle_y(cur.ang_y), .in_angle_z(cur.ang_z),
    .in_scale_x(cur.scl_x), .in_scale_y(cur.scl_y), .in_scale_z(cur.scl_z),
    .done(done),
    .out_col0_row0(out_m[0]), .out_col0_row1(out_m[1]), .out_col0_row2(out_m[2]),
    .out_col1_row0(out_m[3]), .out_col1_row1(out_m[4]), .out_col1_row2(out_m[5]),
    .out_col2_row0(out_m[6]), .out_col2_row1(out_m[7]), .out_col2_row2(out_m[8]),
    .out_trans_x(out_t[0]), .out_trans_y(out_t[1]), .out_trans_z(out_t[2])
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // >>> on signed longint is an arithmetic, i.e. floor, shift
  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic sin_cos(input logic [15:0] a, output longint s, output longint c);
    longint z, x, y, dx, dy, one;
    bit flip;
    z = longint'(a) << 16;
    x = etmc_pkg::CordicX0;
    y = 0;
    one = longint'(1) << TrigBits;
    flip = 1'b0;
    if (z >= (longint'(1) << 30) && z < (longint'(3) << 30)) begin
      z -= longint'(1) << 31;
      flip = 1'b1;
    end else if (z >= (longint'(3) << 30)) begin
      z -= longint'(1) << 32;
    end
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= etmc_pkg::atan_turn(i);
      end else begin
        x += dx; y -= dy; z += etmc_pkg::atan_turn(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(round_sh(x, 30 - TrigBits), -one, one);
    s = clip(round_sh(y, 30 - TrigBits), -one, one);
  endtask

  function automatic logic signed [31:0] scale_entry(longint r2, longint scl);
    longint r;
    r = round_sh(r2, TrigBits);
    return 32'(clip(round_sh(r * scl, TrigBits), -64'sd2147483648, 64'sd2147483647));
  endfunction

  task automatic compose_matrix(input pose_t p, output matrix_t e);
    longint sx, cx, sy, cy, sz, cz, szsx, czsx;
    longint r[9];
    longint scl[3];
    sin_cos(p.ang_x, sx, cx);
    sin_cos(p.ang_y, sy, cy);
    sin_cos(p.ang_z, sz, cz);
    scl[0] = p.scl_x; scl[1] = p.scl_y; scl[2] = p.scl_z;
    szsx = round_sh(sz * sx, TrigBits);
    czsx = round_sh(cz * sx, TrigBits);
    r[0] = cz * cy - szsx * sy;
    r[1] = sz * cy + czsx * sy;
    r[2] = -(cx * sy);
    r[3] = -(sz * cx);
    r[4] = cz * cx;
    r[5] = sx << TrigBits;
    r[6] = cz * sy + szsx * cy;
    r[7] = sz * sy - czsx * cy;
    r[8] = cx * cy;
    for (int k = 0; k < 9; k++) e.m[k] = scale_entry(r[k], scl[k / 3]);
    e.t[0] = p.pos_x; e.t[1] = p.pos_y; e.t[2] = p.pos_z;
  endtask

  // Drive one item from the falling edge; hold start until it is taken.
  task automatic send_pose(input pose_t p);
    matrix_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    cur <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    compose_matrix(p, e);
    matrix_q.push_back(e);
  endtask

  function automatic pose_t rand_pose();
    pose_t p;
    p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
    p.ang_x = 16'($urandom); p.ang_y = 16'($urandom); p.ang_z = 16'($urandom);
    case ($urandom_range(3))
      0: begin
        p.scl_x = 24'($urandom); p.scl_y = 24'($urandom); p.scl_z = 24'($urandom);
      end
      default: begin
        p.scl_x = $signed(24'($urandom_range(0, 2 ** 19))) - 24'sd262144;
        p.scl_y = $signed(24'($urandom_range(0, 2 ** 19))) - 24'sd262144;
        p.scl_z = $signed(24'($urandom_range(0, 2 ** 19))) - 24'sd262144;
      end
    endcase
    return p;
  endfunction

  task automatic test_extremes();
    pose_t p;
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                             16'h3FFF, 16'hBFFF, 16'hFFFF, 16'h2000};
    for (int i = 0; i < 8; i++) begin
      p.pos_x = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
      p.pos_y = 32'sd0;
      p.pos_z = (i % 2) ? -32'sd1 : 32'sh00010000;
      p.ang_x = angs[i]; p.ang_y = angs[(i + 3) % 8]; p.ang_z = angs[(i + 5) % 8];
      p.scl_x = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
      p.scl_y = (i % 3 == 0) ? 24'sh010000 : -24'sh010000;
      p.scl_z = (i % 4 == 0) ? 24'sd0 : 24'sh800000;
      send_pose(p);
    end
  endtask

  task automatic test_overshoot();
    pose_t p;
    // near-zero angles push cosine to its clamp; scales are set to their extreme codes
    for (int i = 0; i < 6; i++) begin
      p = rand_pose();
      p.ang_x = 16'(i - 3); p.ang_y = 16'(i * 7 - 20); p.ang_z = 16'h4000 + 16'(i);
      p.scl_x = 24'sh7FFFFF; p.scl_y = 24'sh800000; p.scl_z = 24'sh7FFFFF;
      send_pose(p);
    end
  endtask

  task automatic test_random(input int n, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (n) send_pose(rand_pose());
    send_idle_pct = 0;
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    matrix_t e;
    if (rst_n && done) begin
      if (matrix_q.size() == 0) begin
        $error("result with no item outstanding");
        failed = 1'b1;
      end else begin
        e = matrix_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_m[k] !== e.m[k]) begin
            $error("col%0d_row%0d: expected %0d, got %0d", k / 3, k % 3, e.m[k], out_m[k]);
            failed = 1'b1;
          end
        for (int k = 0; k < 3; k++)
          if (out_t[k] !== e.t[k]) begin
            $error("trans_%s: expected %0d, got %0d", (k == 0) ? "x" : (k == 1) ? "y" : "z",
                   e.t[k], out_t[k]);
            failed = 1'b1;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_overshoot();
    test_random(630, 19);
    test_random(630, 72);
    test_random(630, 0);
    @(negedge clk);
    start <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
